### hdl/ipt_pkg.sv
`default_nettype none

package ipt_pkg;

    localparam int NODE_COUNT_DEF = 4096;
    localparam int ADDRESS_BITS   = 32;
    localparam int LABEL_W        = 16;
    localparam int INDEX_OUT_W    = 12;
    localparam int LENGTH_W       = 6;
    localparam int LEVEL_W        = $clog2(ADDRESS_BITS + 1);

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef enum logic {
        MODE_LOOKUP = 1'b0,
        MODE_INSERT = 1'b1
    } t_mode;

endpackage

`default_nettype wire

### hdl/ipt_node_mem.sv
`default_nettype none

module ipt_node_mem #(
    parameter int DEPTH = ipt_pkg::NODE_COUNT_DEF,
    parameter int DW    = ipt_pkg::LABEL_W + 2 * $clog2(ipt_pkg::NODE_COUNT_DEF)
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [DW-1:0]            i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [DW-1:0]            o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### hdl/ipv4_prefix_trie.sv
`default_nettype none

// ipv4_prefix_trie: binary trie over ipv4 addresses with longest prefix match.
// a transaction is accepted on a rising edge with start high and busy low.
// i_mode selects lookup (walk up to 32 levels, report the deepest labelled
// node below the root) or insert (walk one level per leading one bit of
// i_prefix_mask, allocate missing nodes, label the final node if unlabelled).
// each transaction gives exactly one result, shown on the o_ result ports for
// one cycle with o_done high; the receiver cannot stall it.
// the walker steps down one trie level at a time, and the result and o_done
// are registered from the walker's state when the walk ends.
// busy stays high from acceptance until the cycle o_done rises; one
// transaction is in flight at a time, since each level needs the node read of
// the level before from the node memory.
// reset: after reset release the init state clears the root entry while busy
// is high, and the free node pointer returns to one.
// when the node memory fills during an insert, nodes already made stay and
// the result carries status full.
module ipv4_prefix_trie #(
    parameter int NODE_COUNT = ipt_pkg::NODE_COUNT_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic                              i_mode,
    input  wire logic [ipt_pkg::ADDRESS_BITS-1:0]  i_address,
    input  wire logic [ipt_pkg::ADDRESS_BITS-1:0]  i_prefix_mask,
    input  wire logic [ipt_pkg::LABEL_W-1:0]       i_label,
    output logic                                   o_done,
    output logic [1:0]                             o_status,
    output logic [ipt_pkg::LABEL_W-1:0]            o_match_label,
    output logic [ipt_pkg::INDEX_OUT_W-1:0]        o_node_index,
    output logic [ipt_pkg::LENGTH_W-1:0]           o_match_length
);

    localparam int IW = $clog2(NODE_COUNT);
    localparam int DW = ipt_pkg::LABEL_W + 2 * IW;
    localparam int LW = ipt_pkg::LEVEL_W;
    localparam int AB = ipt_pkg::ADDRESS_BITS;

    typedef enum logic [1:0] {
        S_INIT,
        S_IDLE,
        S_WALK
    } t_state;

    t_state                      r_state;
    logic                        r_mode;
    logic [AB-1:0]               r_addr;
    logic [AB-1:0]               r_mask;
    logic [ipt_pkg::LABEL_W-1:0] r_label;
    logic [IW-1:0]               r_node;
    logic [LW-1:0]               r_level;
    logic                        r_fresh;
    logic [IW:0]                 r_next_free;
    logic                        r_found;
    logic [IW-1:0]               r_best_node;
    logic [ipt_pkg::LABEL_W-1:0] r_best_label;
    logic [LW-1:0]               r_best_len;
    logic                        r_done;
    logic [1:0]                  r_status;
    logic [ipt_pkg::LABEL_W-1:0] r_out_label;
    logic [IW-1:0]               r_out_node;
    logic [LW-1:0]               r_out_len;

    logic [DW-1:0]               rd_data;
    logic [DW-1:0]               cur;
    logic [ipt_pkg::LABEL_W-1:0] cur_label;
    logic [IW-1:0]               cur_zero;
    logic [IW-1:0]               cur_one;
    logic [IW-1:0]               child;
    logic                        at_end;
    logic                        ins_stop;
    logic                        store_full;
    logic                        set_label;
    logic [ipt_pkg::LABEL_W-1:0] new_label;
    logic                        lab_hit;
    logic                        mem_we;
    logic [IW-1:0]               mem_waddr;
    logic [DW-1:0]               mem_wdata;
    logic [IW-1:0]               mem_raddr;

    assign cur        = r_fresh ? '0 : rd_data;
    assign cur_label  = cur[DW-1 -: ipt_pkg::LABEL_W];
    assign cur_zero   = cur[2*IW-1 -: IW];
    assign cur_one    = cur[IW-1:0];
    assign child      = r_addr[AB-1] ? cur_one : cur_zero;
    assign at_end     = (r_level == LW'(AB));
    assign ins_stop   = at_end || !r_mask[AB-1];
    assign store_full = (r_next_free >= (IW+1)'(NODE_COUNT));
    assign set_label  = (r_label != '0) && (cur_label == '0);
    assign new_label  = set_label ? r_label : cur_label;
    assign lab_hit    = (r_level != '0) && (cur_label != '0);
    assign mem_raddr  = (r_state == S_WALK) ? child : '0;

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_node;
        mem_wdata = cur;
        case (r_state)
            S_INIT: begin
                mem_we    = 1'b1;
                mem_waddr = '0;
                mem_wdata = '0;
            end
            S_WALK: begin
                if (r_mode == ipt_pkg::MODE_INSERT) begin
                    if (ins_stop) begin
                        mem_we    = r_fresh || set_label;
                        mem_wdata = {new_label, cur_zero, cur_one};
                    end else if (child == '0) begin
                        if (store_full) begin
                            mem_we = r_fresh;
                        end else begin
                            mem_we = 1'b1;
                            if (r_addr[AB-1]) begin
                                mem_wdata = {cur_label, cur_zero, r_next_free[IW-1:0]};
                            end else begin
                                mem_wdata = {cur_label, r_next_free[IW-1:0], cur_one};
                            end
                        end
                    end
                end
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    ipt_node_mem #(
        .DEPTH (NODE_COUNT),
        .DW    (DW)
    ) u_node_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_next_free <= (IW+1)'(1);
            r_done      <= 1'b0;
            r_fresh     <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_INIT: begin
                    r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (start) begin
                        r_mode  <= i_mode;
                        r_addr  <= i_address;
                        r_mask  <= i_prefix_mask;
                        r_label <= i_label;
                        r_node  <= '0;
                        r_level <= '0;
                        r_fresh <= 1'b0;
                        r_found <= 1'b0;
                        r_state <= S_WALK;
                    end
                end
                S_WALK: begin
                    if (r_mode == ipt_pkg::MODE_LOOKUP) begin
                        if (lab_hit) begin
                            r_found      <= 1'b1;
                            r_best_node  <= r_node;
                            r_best_label <= cur_label;
                            r_best_len   <= r_level;
                        end
                        if (at_end || child == '0) begin
                            r_done  <= 1'b1;
                            r_state <= S_IDLE;
                            if (lab_hit) begin
                                r_status    <= ipt_pkg::ST_OK;
                                r_out_label <= cur_label;
                                r_out_node  <= r_node;
                                r_out_len   <= r_level;
                            end else if (r_found) begin
                                r_status    <= ipt_pkg::ST_OK;
                                r_out_label <= r_best_label;
                                r_out_node  <= r_best_node;
                                r_out_len   <= r_best_len;
                            end else begin
                                r_status    <= ipt_pkg::ST_MISS;
                                r_out_label <= '0;
                                r_out_node  <= '0;
                                r_out_len   <= '0;
                            end
                        end else begin
                            r_node  <= child;
                            r_level <= r_level + LW'(1);
                            r_addr  <= r_addr << 1;
                        end
                    end else begin
                        if (ins_stop) begin
                            r_done      <= 1'b1;
                            r_state     <= S_IDLE;
                            r_fresh     <= 1'b0;
                            r_status    <= ipt_pkg::ST_OK;
                            r_out_label <= new_label;
                            r_out_node  <= r_node;
                            r_out_len   <= r_level;
                        end else if (child != '0) begin
                            r_node  <= child;
                            r_level <= r_level + LW'(1);
                            r_addr  <= r_addr << 1;
                            r_mask  <= r_mask << 1;
                            r_fresh <= 1'b0;
                        end else if (store_full) begin
                            r_done      <= 1'b1;
                            r_state     <= S_IDLE;
                            r_fresh     <= 1'b0;
                            r_status    <= ipt_pkg::ST_FULL;
                            r_out_label <= cur_label;
                            r_out_node  <= r_node;
                            r_out_len   <= r_level;
                        end else begin
                            r_node      <= r_next_free[IW-1:0];
                            r_next_free <= r_next_free + (IW+1)'(1);
                            r_level     <= r_level + LW'(1);
                            r_addr      <= r_addr << 1;
                            r_mask      <= r_mask << 1;
                            r_fresh     <= 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy           = (r_state != S_IDLE);
    assign o_done         = r_done;
    assign o_status       = r_status;
    assign o_match_label  = r_out_label;
    assign o_node_index   = ipt_pkg::INDEX_OUT_W'(r_out_node);
    assign o_match_length = ipt_pkg::LENGTH_W'(r_out_len);

    a_done_after_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state == S_WALK))
        else $error("result strobe without a walk");

    a_accept_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    a_write_when_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state != S_IDLE))
        else $error("node write while idle");

    a_free_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_next_free != '0) && (r_next_free <= (IW+1)'(NODE_COUNT)))
        else $error("free node pointer out of range");

    a_miss_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == ipt_pkg::ST_MISS) |->
            (o_match_label == '0 && o_match_length == '0))
        else $error("lookup miss with nonzero result");

endmodule

`default_nettype wire
